FILE: design/bbe_pkg.sv
package bbe_pkg;

  localparam int KW = 32;
  localparam int BW = 17;
  localparam logic [BW-1:0] BASIS_ONE = 17'h1_0000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [2:0] CFG_ORDER0  = 3'd0;
  localparam logic [2:0] CFG_LENGTH0 = 3'd1;
  localparam logic [2:0] CFG_ORDER1  = 3'd2;
  localparam logic [2:0] CFG_LENGTH1 = 3'd3;
  localparam logic [2:0] CFG_ORDER2  = 3'd4;
  localparam logic [2:0] CFG_LENGTH2 = 3'd5;
  localparam logic [2:0] CFG_MIN_GAP = 3'd6;
  localparam logic [2:0] CFG_DOM_TOL = 3'd7;

  // knot read address kinds
  typedef enum logic [2:0] {
    KA_LO, KA_HI, KA_SCAN, KA_R, KA_RD, KA_LD, KA_J
  } kaddr_e;

  // where a knot read lands
  typedef enum logic [2:0] {
    CAP_NONE, CAP_LO, CAP_HI, CAP_KR, CAP_KRD, CAP_KLD, CAP_KJ
  } cap_e;

  // basis work read select
  typedef enum logic [1:0] {
    BS_J, BS_JM1, BS_OUT
  } bsel_e;

  typedef struct packed {
    logic   wr_knot;
    logic   load;
    logic   rd_en;
    kaddr_e rd_sel;
    cap_e   cap;
    logic   scan_init;
    logic   scan_step;
    logic   scan_cmp;
    logic   setup;
    logic   scl_start;
    bsel_e  bsel;
    logic   tmp_cap;
    logic   bw_wr;
    logic   bw_add;
    logic   j_next;
    logic   emit;
    logic   emit_bad;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_axis;
    logic ood;
    logic scan_last;
    logic past_end;
    logic order_one;
    logic j_zero;
    logic tri_last;
    logic out_last;
    logic scl_done;
  } dp_stat_t;

endpackage

FILE: design/bspline_basis_eval.sv
// B-spline basis evaluator (Cox-de Boor). Knots for all axes live in one
// memory; an op 0 item writes one knot. An op 1 item reads the domain ends
// and checks t, scans the axis knot vector one knot per cycle, takes a
// setup step, then, unless the span lies past the end or the order is one,
// runs the basis triangle on one shared scale unit over order*(order+1)/2 - 1
// cells. Each cell takes four knot reads plus one or two scale passes; a
// pass skips the multiply and divide when the ratio clamps or the gap drops,
// else it runs a multiply and a 17-step restoring divide. Results then leave
// one per cycle on res_valid_o, order beats per evaluation (one flagged beat
// when t or the axis is out of range). start_i is taken only while busy_o is
// low; the receiver cannot stall, so every result beat must be captured when
// it shows.
module bspline_basis_eval #(
  parameter int MAX_ORDER = 16,
  parameter int MAX_CTRL  = 64,
  parameter int AXES      = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [1:0]         axis_i,
  input  logic [6:0]         knot_slot_i,
  input  logic signed [31:0] knot_value_i,
  input  logic signed [31:0] param_t_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               res_valid_o,
  output logic [3:0]         basis_slot_o,
  output logic [16:0]        basis_value_o,
  output logic [5:0]         first_index_o,
  output logic               out_of_domain_o,
  output logic               last_o
);
  import bbe_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bbe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  bbe_dp #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_CTRL  (MAX_CTRL),
    .AXES      (AXES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .axis_i          (axis_i),
    .knot_slot_i     (knot_slot_i),
    .knot_value_i    (knot_value_i),
    .param_t_i       (param_t_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .res_valid_o     (res_valid_o),
    .basis_slot_o    (basis_slot_o),
    .basis_value_o   (basis_value_o),
    .first_index_o   (first_index_o),
    .out_of_domain_o (out_of_domain_o),
    .last_o          (last_o)
  );

endmodule

FILE: design/bbe_scale.sv
module bbe_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bbe_pkg::BW-1:0]    b_i,
  input  logic signed [32:0]        num_i,
  input  logic signed [32:0]        gap_i,
  input  logic [15:0]               min_gap_i,
  output logic                      done_o,
  output logic [bbe_pkg::BW-1:0]    res_o
);
  import bbe_pkg::*;

  localparam int CW = $clog2(BW);

  logic          mul_q, div_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [BW-1:0] b_q, low_q, quo_q, res_q;
  logic [31:0]   num_q, gap_q;
  logic [32:0]   rem_q;

  logic          zero_c, pass_c, fit_c;
  logic [48:0]   mul_c;
  logic [49:0]   prod_c;
  logic [33:0]   rem2_c, diff_c;

  always_comb begin
    zero_c = (gap_i <= 33'sd0) || (gap_i < $signed({17'b0, min_gap_i})) ||
             (num_i <= 33'sd0);
    pass_c = num_i >= gap_i;
    mul_c  = {32'b0, b_q} * {17'b0, num_q};
    // round half up: add gap/2 before the divide
    prod_c = {1'b0, mul_c} + {19'b0, gap_q[31:1]};
    rem2_c = {rem_q, low_q[BW-1]};
    fit_c  = rem2_c >= {2'b0, gap_q};
    diff_c = rem2_c - {2'b0, gap_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (zero_c || pass_c) done_q <= 1'b1;
        else mul_q <= 1'b1;
      end else if (mul_q) begin
        mul_q <= 1'b0;
        div_q <= 1'b1;
        cnt_q <= '0;
      end else if (div_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(BW - 1)) begin
          div_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient is below 2^BW, so the top of the product is already under gap
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      b_q   <= b_i;
      num_q <= num_i[31:0];
      gap_q <= gap_i[31:0];
      if (zero_c) res_q <= '0;
      else if (pass_c) res_q <= b_i;
    end else if (mul_q) begin
      rem_q <= prod_c[49:BW];
      low_q <= prod_c[BW-1:0];
    end else if (div_q) begin
      rem_q <= fit_c ? diff_c[32:0] : rem2_c[32:0];
      low_q <= {low_q[BW-2:0], 1'b0};
      quo_q <= {quo_q[BW-2:0], fit_c};
      if (cnt_q == CW'(BW - 1)) res_q <= {quo_q[BW-2:0], fit_c};
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: design/bbe_dp.sv
module bbe_dp #(
  parameter int MAX_ORDER = 16,
  parameter int MAX_CTRL  = 64,
  parameter int AXES      = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bbe_pkg::dp_cmd_t       cmd_i,
  output bbe_pkg::dp_stat_t      stat_o,
  input  logic [1:0]             axis_i,
  input  logic [6:0]             knot_slot_i,
  input  logic signed [31:0]     knot_value_i,
  input  logic signed [31:0]     param_t_i,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  output logic                   res_valid_o,
  output logic [3:0]             basis_slot_o,
  output logic [16:0]            basis_value_o,
  output logic [5:0]             first_index_o,
  output logic                   out_of_domain_o,
  output logic                   last_o
);
  import bbe_pkg::*;

  localparam int KPA   = MAX_ORDER + MAX_CTRL;
  localparam int DEPTH = AXES * KPA;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(KPA);
  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int LW    = $clog2(MAX_CTRL + 1);
  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  // configuration
  logic [4:0]  ord_raw_q [3];
  logic [6:0]  len_raw_q [3];
  logic [15:0] mkg_q, tol_q;

  // knot memory
  logic [KW-1:0] mem_q [DEPTH];
  logic [KW-1:0] rdata_q;
  logic [AW-1:0] wa_c, ra_c;
  logic [SW-1:0] slot_c;
  logic          wr_ok_c;

  // evaluation registers
  logic [1:0]           axis_q;
  logic signed [31:0]   t_q;
  logic [OW-1:0]        order_q;
  logic [LW-1:0]        length_q;
  logic signed [31:0]   klo_q, khi_q, kr_q, krd_q, kld_q, kj_q;
  logic [SW-1:0]        i_q, pidx_q, span_q;
  logic                 pval_q;
  logic [IW-1:0]        d_q, j_q, oidx_q;
  logic [LW-1:0]        first_q;
  logic [BW-1:0]        tmp_q;
  logic [BW-1:0]        bw_q [MAX_ORDER];

  logic                 res_valid_q, ood_q, last_q;
  logic [3:0]           slot_q;
  logic [BW-1:0]        value_q;
  logic [5:0]           first_o_q;

  logic [4:0]           ord_sel_c;
  logic [6:0]           len_sel_c;
  logic [OW-1:0]        ord_clamp_c;
  logic [LW-1:0]        len_clamp_c;
  logic signed [32:0]   lo_c, hi_c, t33_c, num_c, gap_c;
  logic [IW-1:0]        bidx_c;
  logic [BW-1:0]        b_rd_c, scl_res;
  logic [BW:0]          sum_c;
  logic                 past_c, scl_done;

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ord_raw_q[k] <= 5'd4;
        len_raw_q[k] <= 7'd4;
      end
      mkg_q <= 16'd1;
      tol_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORDER0:  ord_raw_q[0] <= cfg_data_i[4:0];
        CFG_LENGTH0: len_raw_q[0] <= cfg_data_i[6:0];
        CFG_ORDER1:  ord_raw_q[1] <= cfg_data_i[4:0];
        CFG_LENGTH1: len_raw_q[1] <= cfg_data_i[6:0];
        CFG_ORDER2:  ord_raw_q[2] <= cfg_data_i[4:0];
        CFG_LENGTH2: len_raw_q[2] <= cfg_data_i[6:0];
        CFG_MIN_GAP: mkg_q <= cfg_data_i;
        CFG_DOM_TOL: tol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ord_sel_c = (axis_i == 2'd1) ? ord_raw_q[1] :
                (axis_i == 2'd2) ? ord_raw_q[2] : ord_raw_q[0];
    len_sel_c = (axis_i == 2'd1) ? len_raw_q[1] :
                (axis_i == 2'd2) ? len_raw_q[2] : len_raw_q[0];
    if (ord_sel_c == '0) ord_clamp_c = OW'(1);
    else if (32'(ord_sel_c) > MAX_ORDER) ord_clamp_c = OW'(MAX_ORDER);
    else ord_clamp_c = OW'(ord_sel_c);
    if (len_sel_c == '0) len_clamp_c = LW'(1);
    else if (32'(len_sel_c) > MAX_CTRL) len_clamp_c = LW'(MAX_CTRL);
    else len_clamp_c = LW'(len_sel_c);
  end

  // knot addresses
  always_comb begin
    wr_ok_c = (32'(axis_i) < AXES) && (32'(knot_slot_i) < KPA);
    wa_c    = AW'(32'(axis_i) * KPA + 32'(knot_slot_i));
    case (cmd_i.rd_sel)
      KA_LO:   slot_c = SW'(32'(order_q) - 1);
      KA_HI:   slot_c = SW'(length_q);
      KA_SCAN: slot_c = i_q;
      KA_R:    slot_c = SW'(32'(span_q) + 32'(j_q) + 1);
      KA_RD:   slot_c = SW'(32'(span_q) + 32'(j_q) + 1 - 32'(d_q));
      KA_LD:   slot_c = SW'(32'(span_q) + 32'(j_q) - 32'(d_q));
      KA_J:    slot_c = SW'(32'(span_q) + 32'(j_q));
      default: slot_c = '0;
    endcase
    ra_c = AW'(32'(axis_q) * KPA + 32'(slot_c));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_knot && wr_ok_c) mem_q[wa_c] <= knot_value_i;
    if (cmd_i.rd_en) rdata_q <= mem_q[ra_c];
  end

  // status
  always_comb begin
    t33_c  = $signed({t_q[31], t_q});
    lo_c   = $signed({klo_q[31], klo_q}) - $signed({17'b0, tol_q});
    hi_c   = $signed({khi_q[31], khi_q}) + $signed({17'b0, tol_q});
    past_c = 32'(span_q) >= 32'(length_q);

    stat_o.bad_axis  = 32'(axis_q) >= AXES;
    stat_o.ood       = (t33_c < lo_c) || (t33_c > hi_c);
    stat_o.scan_last = 32'(i_q) + 1 == 32'(order_q) + 32'(length_q);
    stat_o.past_end  = past_c;
    stat_o.order_one = order_q == OW'(1);
    stat_o.j_zero    = j_q == '0;
    stat_o.tri_last  = (32'(d_q) + 1 == 32'(order_q)) && (j_q == '0);
    stat_o.out_last  = 32'(oidx_q) + 1 == 32'(order_q);
    stat_o.scl_done  = scl_done;
  end

  // basis work read and scale operands
  always_comb begin
    case (cmd_i.bsel)
      BS_J:    bidx_c = j_q;
      BS_JM1:  bidx_c = j_q - 1'b1;
      BS_OUT:  bidx_c = oidx_q;
      default: bidx_c = j_q;
    endcase
    b_rd_c = bw_q[bidx_c];
    if (cmd_i.bsel == BS_JM1) begin
      num_c = t33_c - $signed({kld_q[31], kld_q});
      gap_c = $signed({kj_q[31], kj_q}) - $signed({kld_q[31], kld_q});
    end else begin
      num_c = $signed({kr_q[31], kr_q}) - t33_c;
      gap_c = $signed({kr_q[31], kr_q}) - $signed({krd_q[31], krd_q});
    end
    sum_c = {1'b0, tmp_q} + (cmd_i.bw_add ? {1'b0, scl_res} : '0);
  end

  bbe_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.scl_start),
    .b_i       (b_rd_c),
    .num_i     (num_c),
    .gap_i     (gap_c),
    .min_gap_i (mkg_q),
    .done_o    (scl_done),
    .res_o     (scl_res)
  );

  // evaluation payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      axis_q   <= axis_i;
      t_q      <= param_t_i;
      order_q  <= ord_clamp_c;
      length_q <= len_clamp_c;
    end
    case (cmd_i.cap)
      CAP_LO:  klo_q <= rdata_q;
      CAP_HI:  khi_q <= rdata_q;
      CAP_KR:  kr_q  <= rdata_q;
      CAP_KRD: krd_q <= rdata_q;
      CAP_KLD: kld_q <= rdata_q;
      CAP_KJ:  kj_q  <= rdata_q;
      default: ;
    endcase
    if (cmd_i.scan_init) begin
      i_q    <= '0;
      span_q <= SW'(32'(order_q) - 1);
    end
    if (cmd_i.scan_step) begin
      i_q    <= i_q + 1'b1;
      pidx_q <= i_q;
    end
    // only spans at or above order-1 can win; the last qualifying knot wins
    if (cmd_i.scan_cmp && pval_q && ($signed(rdata_q) <= t_q) &&
        (32'(pidx_q) + 1 >= 32'(order_q)))
      span_q <= pidx_q;
    if (cmd_i.setup) begin
      d_q    <= IW'(1);
      j_q    <= IW'(1);
      oidx_q <= '0;
      if (past_c)
        first_q <= (32'(length_q) >= 32'(order_q)) ?
                   LW'(32'(length_q) - 32'(order_q)) : '0;
      else
        first_q <= LW'(32'(span_q) + 1 - 32'(order_q));
    end
    if (cmd_i.j_next) begin
      if (j_q == '0) begin
        d_q <= d_q + 1'b1;
        j_q <= d_q + 1'b1;
      end else begin
        j_q <= j_q - 1'b1;
      end
    end
    if (cmd_i.tmp_cap) tmp_q <= scl_res;
    if (cmd_i.emit) oidx_q <= oidx_q + 1'b1;
    if (cmd_i.emit) begin
      slot_q    <= 4'(oidx_q);
      value_q   <= b_rd_c;
      first_o_q <= 6'(first_q);
      ood_q     <= 1'b0;
      last_q    <= 32'(oidx_q) + 1 == 32'(order_q);
    end else if (cmd_i.emit_bad) begin
      slot_q    <= '0;
      value_q   <= '0;
      first_o_q <= '0;
      ood_q     <= 1'b1;
      last_q    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pval_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) bw_q[k] <= '0;
    end else begin
      res_valid_q <= cmd_i.emit || cmd_i.emit_bad;
      if (cmd_i.scan_init) pval_q <= 1'b0;
      else if (cmd_i.scan_step) pval_q <= 1'b1;
      if (cmd_i.setup) begin
        // past the end only the last slot starts at one, else slot zero
        for (int k = 0; k < MAX_ORDER; k++)
          bw_q[k] <= (past_c ? (k == 32'(order_q) - 1) : (k == 0)) ? BASIS_ONE : '0;
      end else if (cmd_i.bw_wr) begin
        bw_q[j_q] <= (sum_c > {1'b0, BASIS_ONE}) ? BASIS_ONE : sum_c[BW-1:0];
      end
    end
  end

  assign res_valid_o     = res_valid_q;
  assign basis_slot_o    = slot_q;
  assign basis_value_o   = value_q;
  assign first_index_o   = first_o_q;
  assign out_of_domain_o = ood_q;
  assign last_o          = last_q;

endmodule

FILE: design/bbe_ctrl.sv
module bbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              op_i,
  input  bbe_pkg::dp_stat_t stat_i,
  output bbe_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);
  import bbe_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LO       = 5'd1;
  localparam logic [4:0] S_HI       = 5'd2;
  localparam logic [4:0] S_CHK0     = 5'd3;
  localparam logic [4:0] S_CHK1     = 5'd4;
  localparam logic [4:0] S_SCAN     = 5'd5;
  localparam logic [4:0] S_SCAN_END = 5'd6;
  localparam logic [4:0] S_SETUP    = 5'd7;
  localparam logic [4:0] S_K0       = 5'd8;
  localparam logic [4:0] S_K1       = 5'd9;
  localparam logic [4:0] S_K2       = 5'd10;
  localparam logic [4:0] S_K3       = 5'd11;
  localparam logic [4:0] S_K4       = 5'd12;
  localparam logic [4:0] S_RA       = 5'd13;
  localparam logic [4:0] S_RA_WAIT  = 5'd14;
  localparam logic [4:0] S_LB       = 5'd15;
  localparam logic [4:0] S_LB_WAIT  = 5'd16;
  localparam logic [4:0] S_WB       = 5'd17;
  localparam logic [4:0] S_NEXT     = 5'd18;
  localparam logic [4:0] S_OUT      = 5'd19;
  localparam logic [4:0] S_BAD      = 5'd20;

  logic [4:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (op_i == OP_WRITE) begin
            cmd_o.wr_knot = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_LO;
          end
        end
      end
      S_LO: begin
        if (stat_i.bad_axis) begin
          state_d = S_BAD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = KA_LO;
          state_d      = S_HI;
        end
      end
      S_HI: begin
        cmd_o.cap    = CAP_LO;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = KA_HI;
        state_d      = S_CHK0;
      end
      S_CHK0: begin
        cmd_o.cap = CAP_HI;
        state_d   = S_CHK1;
      end
      S_CHK1: begin
        if (stat_i.ood) begin
          state_d = S_BAD;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        // one knot read per cycle; the compare works on the registered read of the previous knot
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = KA_SCAN;
        cmd_o.scan_step = 1'b1;
        cmd_o.scan_cmp  = 1'b1;
        if (stat_i.scan_last) state_d = S_SCAN_END;
      end
      S_SCAN_END: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (stat_i.past_end || stat_i.order_one) state_d = S_OUT;
        else state_d = S_K0;
      end
      S_K0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = KA_R;
        state_d      = S_K1;
      end
      S_K1: begin
        cmd_o.cap    = CAP_KR;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = KA_RD;
        state_d      = S_K2;
      end
      S_K2: begin
        cmd_o.cap    = CAP_KRD;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = KA_LD;
        state_d      = S_K3;
      end
      S_K3: begin
        cmd_o.cap    = CAP_KLD;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = KA_J;
        state_d      = S_K4;
      end
      S_K4: begin
        cmd_o.cap = CAP_KJ;
        state_d   = S_RA;
      end
      S_RA: begin
        cmd_o.bsel      = BS_J;
        cmd_o.scl_start = 1'b1;
        state_d         = S_RA_WAIT;
      end
      S_RA_WAIT: begin
        if (stat_i.scl_done) begin
          cmd_o.tmp_cap = 1'b1;
          state_d       = stat_i.j_zero ? S_WB : S_LB;
        end
      end
      S_LB: begin
        cmd_o.bsel      = BS_JM1;
        cmd_o.scl_start = 1'b1;
        state_d         = S_LB_WAIT;
      end
      S_LB_WAIT: begin
        if (stat_i.scl_done) begin
          cmd_o.bw_wr  = 1'b1;
          cmd_o.bw_add = 1'b1;
          state_d      = S_NEXT;
        end
      end
      S_WB: begin
        cmd_o.bw_wr = 1'b1;
        state_d     = S_NEXT;
      end
      S_NEXT: begin
        if (stat_i.tri_last) begin
          state_d = S_OUT;
        end else begin
          cmd_o.j_next = 1'b1;
          state_d      = S_K0;
        end
      end
      S_OUT: begin
        cmd_o.bsel = BS_OUT;
        cmd_o.emit = 1'b1;
        if (stat_i.out_last) state_d = S_IDLE;
      end
      S_BAD: begin
        cmd_o.emit_bad = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = state_q != S_IDLE;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bbe_pkg::*;

  localparam int         KNOTS    = 80;
  localparam logic [1:0] BAD_AXIS = 2'd3;
  localparam int         WD_LIMIT = 100000;
  localparam longint     Q_MIN    = -64'sd2147483648;
  localparam longint     Q_MAX    = 64'sd2147483647;

  typedef struct packed {
    logic [3:0]  slot;
    logic [16:0] value;
    logic [5:0]  first;
    logic        ood;
    logic        last;
  } basis_beat_t;

  class basis_scoreboard;
    logic [31:0]   knots[3*KNOTS];
    logic [4:0]    ord_r[3];
    logic [6:0]    len_r[3];
    logic [15:0]   min_gap;
    logic [15:0]   dom_tol;
    basis_beat_t   expected_q[$];
    int            errors, beats, n_eval, n_ood, n_write;

    function new();
      foreach (knots[i]) knots[i] = '0;
      foreach (ord_r[i]) begin
        ord_r[i] = 5'd4;
        len_r[i] = 7'd4;
      end
      min_gap = 16'd1;
      dom_tol = 16'd1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        CFG_ORDER0:  ord_r[0] = d[4:0];
        CFG_LENGTH0: len_r[0] = d[6:0];
        CFG_ORDER1:  ord_r[1] = d[4:0];
        CFG_LENGTH1: len_r[1] = d[6:0];
        CFG_ORDER2:  ord_r[2] = d[4:0];
        CFG_LENGTH2: len_r[2] = d[6:0];
        CFG_MIN_GAP: min_gap  = d;
        CFG_DOM_TOL: dom_tol  = d;
        default: ;
      endcase
    endfunction

    function int eff_order(int a);
      return ord_r[a] == 0 ? 1 : (ord_r[a] > 16 ? 16 : int'(ord_r[a]));
    endfunction

    function int eff_length(int a);
      return len_r[a] == 0 ? 1 : (len_r[a] > 64 ? 64 : int'(len_r[a]));
    endfunction

    function longint knot(int a, longint s);
      longint v;
      v = $signed(knots[a*KNOTS + int'(s)]);
      return v;
    endfunction

    // b * num / gap, ratio clamped to [0,1], rounded half up
    function longint ratio_scale(longint b, longint num, longint gap);
      if (gap <= 0 || gap < longint'(min_gap)) return 0;
      if (num <= 0) return 0;
      if (num >= gap) return b;
      return (b * num + gap / 2) / gap;
    endfunction

    function void note_item(logic op, logic [1:0] ax, logic [6:0] kslot,
                            logic [31:0] kval, logic [31:0] t_raw);
      longint t, lo, hi, span, order, length, first, kr, kl, s;
      longint bw[16];
      int a;
      basis_beat_t e;
      a = int'(ax);
      if (op == OP_WRITE) begin
        n_write++;
        if (ax != BAD_AXIS && kslot < KNOTS) knots[a*KNOTS + int'(kslot)] = kval;
        return;
      end
      n_eval++;
      e = '{slot: 4'd0, value: 17'd0, first: 6'd0, ood: 1'b1, last: 1'b1};
      if (ax == BAD_AXIS) begin
        n_ood++;
        expected_q.push_back(e);
        return;
      end
      t = $signed(t_raw);
      order  = eff_order(a);
      length = eff_length(a);
      lo = knot(a, order - 1) - longint'(dom_tol);
      hi = knot(a, length) + longint'(dom_tol);
      if (t < lo || t > hi) begin
        n_ood++;
        expected_q.push_back(e);
        return;
      end
      span = -1;
      for (int i = 0; i < order + length; i++)
        if (knot(a, i) <= t) span = i;
      if (span < order - 1) span = order - 1;
      foreach (bw[i]) bw[i] = 0;
      if (span >= length) begin
        bw[order-1] = 65536;
        first = length - order;
        if (first < 0) first = 0;
      end else begin
        bw[0] = 65536;
        for (int d = 1; d < order; d++) begin
          for (int j = d; j >= 0; j--) begin
            kr = knot(a, span + j + 1);
            bw[j] = ratio_scale(bw[j], kr - t, kr - knot(a, span + j + 1 - d));
            if (j > 0) begin
              kl = knot(a, span + j - d);
              s = bw[j] + ratio_scale(bw[j-1], t - kl, knot(a, span + j) - kl);
              bw[j] = s > 65536 ? 65536 : s;
            end
          end
        end
        first = span - order + 1;
        if (first >= length) first -= length;
      end
      for (int j = 0; j < order; j++) begin
        e.slot  = 4'(j);
        e.value = 17'(bw[j]);
        e.first = 6'(first);
        e.ood   = 1'b0;
        e.last  = (j == order - 1);
        expected_q.push_back(e);
      end
    endfunction

    function void cmp(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(basis_beat_t got);
      basis_beat_t e;
      beats++;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: slot %0d value %0d", got.slot, got.value);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("basis_slot", e.slot, got.slot);
      cmp("basis_value", e.value, got.value);
      cmp("first_index", e.first, got.first);
      cmp("out_of_domain", e.ood, got.ood);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               op_i = OP_WRITE;
  logic [1:0]         axis_i = '0;
  logic [6:0]         knot_slot_i = '0;
  logic signed [31:0] knot_value_i = '0;
  logic signed [31:0] param_t_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = CFG_ORDER0;
  logic [15:0]        cfg_data_i = '0;
  logic               res_valid_o;
  logic [3:0]         basis_slot_o;
  logic [16:0]        basis_value_o;
  logic [5:0]         first_index_o;
  logic               out_of_domain_o;
  logic               last_o;

  basis_scoreboard sb = new();
  int stall_cycles = 0;
  int n_settings = 1;
  bit burst = 1'b0;

  bspline_basis_eval u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    bit seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (res_valid_o) begin
        sb.check_beat('{basis_slot_o, basis_value_o, first_index_o, out_of_domain_o, last_o});
        seen = 1'b1;
      end
      if (start_i && !busy_o) begin
        sb.note_item(op_i, axis_i, knot_slot_i, knot_value_i, param_t_i);
        seen = 1'b1;
      end
      stall_cycles <= seen ? 0 : stall_cycles + 1;
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_data_i);
      if (stall_cycles >= WD_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WD_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] fit32(longint v);
    if (v < Q_MIN) v = Q_MIN;
    if (v > Q_MAX) v = Q_MAX;
    return v[31:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 200);
  endfunction

  task automatic send(logic op, logic [1:0] ax, logic [6:0] kslot,
                      logic [31:0] kval, logic [31:0] t);
    @(negedge clk_i);
    op_i         <= op;
    axis_i       <= ax;
    knot_slot_i  <= kslot;
    knot_value_i <= kval;
    param_t_i    <= t;
    start_i      <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic rest(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // knot-only beats give no result, so busy_o has to be watched as well
  task automatic wait_drained(int extra);
    rest(1);
    while (sb.expected_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] d);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_cfg(int o0, int l0, int o1, int l1, int o2, int l2, int gap, int tol);
    wait_drained(40);
    write_cfg(CFG_ORDER0, 16'(o0));
    write_cfg(CFG_LENGTH0, 16'(l0));
    write_cfg(CFG_ORDER1, 16'(o1));
    write_cfg(CFG_LENGTH1, 16'(l1));
    write_cfg(CFG_ORDER2, 16'(o2));
    write_cfg(CFG_LENGTH2, 16'(l2));
    write_cfg(CFG_MIN_GAP, 16'(gap));
    write_cfg(CFG_DOM_TOL, 16'(tol));
    n_settings++;
  endtask

  // mode 0 clamped ends, 1 random with repeats and tiny gaps, 2 extreme ends;
  // only the order + length knots that an evaluation reads are loaded
  task automatic load_axis(int a, int mode);
    longint v;
    int ord, len, r;
    ord = sb.eff_order(a);
    len = sb.eff_length(a);
    v = -longint'($urandom_range(0, 1 << 20));
    for (int i = 0; i < ord + len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && !(mode == 0 && (i < ord || i > len))) begin
        if (r < 30) v += 0;
        else if (r < 50) v += $urandom_range(1, 3);
        else v += $urandom_range(1, 1 << 18);
      end
      if (mode == 2 && i < ord) send(OP_WRITE, 2'(a), 7'(i), fit32(Q_MIN), $urandom);
      else if (mode == 2 && i >= len) send(OP_WRITE, 2'(a), 7'(i), fit32(Q_MAX), $urandom);
      else send(OP_WRITE, 2'(a), 7'(i), fit32(v), $urandom);
      rest($urandom_range(0, 9) == 0);
    end
  endtask

  function automatic logic [31:0] pick_t(int a);
    longint lo, hi, w, tmp;
    int ord, len, r;
    ord = sb.eff_order(a);
    len = sb.eff_length(a);
    lo = sb.knot(a, ord - 1) - longint'(sb.dom_tol);
    hi = sb.knot(a, len) + longint'(sb.dom_tol);
    if (hi < lo) begin
      tmp = lo; lo = hi; hi = tmp;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      w = longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % (hi - lo + 1);
      return fit32(lo + w);
    end
    if (r < 80)
      return fit32(sb.knot(a, $urandom_range(0, ord + len - 1)) + $urandom_range(0, 2) - 1);
    if (r < 95) begin
      case ($urandom_range(0, 3))
        0: return fit32(lo - 1);
        1: return fit32(lo);
        2: return fit32(hi);
        default: return fit32(hi + 1);
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_random(int n);
    int k, r, a, slot;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      if (k == n / 2) wait_drained(0);
      r = $urandom_range(0, 99);
      a = $urandom_range(0, 2);
      if (r < 70) begin
        send(OP_EVAL, 2'(a), 7'($urandom), $urandom, pick_t(a));
        k++;
      end else if (r < 78) begin
        slot = $urandom_range(0, KNOTS - 1);
        send(OP_WRITE, 2'(a), 7'(slot),
             fit32(sb.knot(a, slot) + $urandom_range(0, 1 << 17) - (1 << 16)), $urandom);
        k++;
      end else if (r < 84) begin
        // ignored: bad axis or slot past the store
        if ($urandom_range(0, 1)) send(OP_WRITE, BAD_AXIS, 7'($urandom), $urandom, $urandom);
        else send(OP_WRITE, 2'(a), 7'($urandom_range(KNOTS, 127)), $urandom, $urandom);
      end else if (r < 90) begin
        send(OP_EVAL, BAD_AXIS, 7'($urandom), $urandom, $urandom);
        k++;
      end else begin
        send(OP_EVAL, 2'(a), 7'($urandom), $urandom, $urandom);
        k++;
      end
      rest(pick_gap());
    end
  endtask

  initial begin
    longint k3, k4;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: order 4, length 4 on every axis
    load_axis(0, 0);
    load_axis(1, 2);
    load_axis(2, 1);
    k3 = sb.knot(0, 3);
    k4 = sb.knot(0, 4);
    send(OP_EVAL, 2'd0, '0, '0, fit32(k3 - 1));
    send(OP_EVAL, 2'd0, '1, '1, fit32(k3 - 2));
    send(OP_EVAL, 2'd0, '0, '0, fit32(k3));
    send(OP_EVAL, 2'd0, '0, '0, fit32((k3 + k4) / 2));
    send(OP_EVAL, 2'd0, '0, '0, fit32(k4));
    send(OP_EVAL, 2'd0, '0, '0, fit32(k4 + 1));
    send(OP_EVAL, 2'd0, '0, '0, fit32(k4 + 2));
    send(OP_EVAL, 2'd1, '0, '0, fit32(Q_MIN));
    send(OP_EVAL, 2'd1, '0, '0, fit32(Q_MAX));
    send(OP_EVAL, 2'd1, '0, '0, '0);
    send(OP_EVAL, BAD_AXIS, '0, '0, '0);
    send(OP_WRITE, BAD_AXIS, 7'd5, '1, '1);
    send(OP_WRITE, 2'd0, 7'd80, '0, '0);
    send(OP_WRITE, 2'd0, 7'd127, '1, '0);
    send(OP_EVAL, 2'd2, '1, '1, pick_t(2));
    rest(1);
    run_random(20);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_cfg(1, 1, 2, 5, 3, 8, 0, 0);
        1: set_cfg(16, 127, 4, 10, 31, 2, 65535, 65535);
        2: set_cfg(0, 0, 5, 3, 8, 20, 100, 0);
        default: set_cfg($urandom_range(1, 6), $urandom_range(1, 12),
                         $urandom_range(1, 6), $urandom_range(4, 12),
                         $urandom_range(2, 6), $urandom_range(6, 14),
                         $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 4),
                         $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 2));
      endcase
      for (int a = 0; a < 3; a++) load_axis(a, $urandom_range(0, 2));
      run_random(p == 1 ? 8 : 15);
    end

    wait_drained(60);
    $display("Ran %0d evaluations (%0d flagged out of domain) and %0d knot writes",
             sb.n_eval, sb.n_ood, sb.n_write);
    $display("over %0d register settings; %0d result beats checked",
             n_settings, sb.beats);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bbe_pkg.sv
design/bbe_scale.sv
design/bbe_dp.sv
design/bbe_ctrl.sv
design/bspline_basis_eval.sv
test/tb_top.sv
